// File: rtl/rstwa_pkg.sv
// ----------------------------------------------------------------------------
// Relay session table package
// Shared widths, codes, the session entry type and the controller states.
// ----------------------------------------------------------------------------
package rstwa_pkg;

   localparam int SLOTS_DEFAULT    = 16;
   localparam int AGE_BITS_DEFAULT = 8;

   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int TYPE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int TMO_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [TYPE_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RELAY = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_NONE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_TICK_DONE = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RELAYED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_BASE = 1'd1;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] caller_addr;
      logic [PORT_W-1:0] caller_port;
      logic [ADDR_W-1:0] callee_addr;
      logic [PORT_W-1:0] callee_port;
      logic              peer;
   } entry_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_FILL,
      CTL_RESP
   } ctl_state_type;

endpackage

// File: rtl/rstwa_cell.sv
// ----------------------------------------------------------------------------
// Session cell
// Holds one session entry and its age, and passes both to its neighbour on
// every rotation step of the ring.
// ----------------------------------------------------------------------------
module rstwa_cell #(
   parameter int AGE_BITS = rstwa_pkg::AGE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  rstwa_pkg::entry_type  entry_in,
   input  logic [AGE_BITS-1:0]   age_in,
   output rstwa_pkg::entry_type  entry_out,
   output logic [AGE_BITS-1:0]   age_out
);

   rstwa_pkg::entry_type  entry_ff;
   logic [AGE_BITS-1:0]   age_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         age_ff   <= '0;
      end else if (shift_en) begin
         entry_ff <= entry_in;
         age_ff   <= age_in;
      end
   end

   assign entry_out = entry_ff;
   assign age_out   = age_ff;

endmodule

// File: rtl/relay_session_table_with_aging_top.sv
// Timing: a tick, a found or full allocate and a relay offer their result after
// one scan pass of the ring; a created allocate offers it after a further fill pass.
// Throughput: one transaction at a time; the next is accepted only once the ring
// passes are done and the result has been taken, set by the passes and rsp_stall.
// Reset clears every session, restores timeout 30 and port base 50000, and
// the block is ready in the next cycle.
// ----------------------------------------------------------------------------
// Relay session table with aging
// A ring of session cells rotates past one head unit that ages, matches,
// reclaims, creates and relays, one slot per cycle in index order.
// ----------------------------------------------------------------------------
module relay_session_table_with_aging_top #(
   parameter int SLOTS    = rstwa_pkg::SLOTS_DEFAULT,
   parameter int AGE_BITS = rstwa_pkg::AGE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rstwa_pkg::TYPE_W-1:0]      req_type,
   input  logic [rstwa_pkg::ADDR_W-1:0]      req_src_addr,
   input  logic [rstwa_pkg::PORT_W-1:0]      req_src_port,
   input  logic [rstwa_pkg::SLOT_W-1:0]      req_slot_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rstwa_pkg::STATUS_W-1:0]    rsp_status_code,
   output logic [rstwa_pkg::SLOT_W-1:0]      rsp_result_slot,
   output logic [rstwa_pkg::PORT_W-1:0]      rsp_relay_port,
   output logic [rstwa_pkg::ADDR_W-1:0]      rsp_dest_addr,
   output logic [rstwa_pkg::PORT_W-1:0]      rsp_dest_port,
   input  logic                              csr_write_en,
   input  logic [rstwa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rstwa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int POS_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMP_W = 17;

   rstwa_pkg::ctl_state_type state_ff, state_in;

   logic [rstwa_pkg::TMO_W-1:0]   timeout_ff;
   logic [rstwa_pkg::PORT_W-1:0]  base_ff;

   logic [rstwa_pkg::TYPE_W-1:0]  op_ff;
   logic [rstwa_pkg::ADDR_W-1:0]  addr_ff;
   logic [rstwa_pkg::PORT_W-1:0]  port_ff;
   logic [rstwa_pkg::SLOT_W-1:0]  idx_ff;
   logic [POS_W-1:0]              pos_ff;
   logic                          done_ff;
   logic                          relay_ok_ff;
   logic                          free_found_ff;
   logic [POS_W-1:0]              free_slot_ff;

   logic [rstwa_pkg::STATUS_W-1:0] res_status_ff;
   logic [rstwa_pkg::SLOT_W-1:0]   res_slot_ff;
   logic [rstwa_pkg::PORT_W-1:0]   res_rp_ff;
   logic [rstwa_pkg::ADDR_W-1:0]   res_da_ff;
   logic [rstwa_pkg::PORT_W-1:0]   res_dp_ff;

   rstwa_pkg::entry_type cell_entry [SLOTS];
   logic [AGE_BITS-1:0]  cell_age   [SLOTS];
   rstwa_pkg::entry_type head_entry;
   logic [AGE_BITS-1:0]  head_age;
   rstwa_pkg::entry_type cur;
   logic [AGE_BITS-1:0]  cur_age;

   logic shift_en, accept, last;
   logic hit, free_now, relay_ok;
   logic [rstwa_pkg::ADDR_W-1:0] relay_da;
   logic [rstwa_pkg::PORT_W-1:0] relay_dp;
   logic [rstwa_pkg::PORT_W-1:0] pos_port;
   logic caller_eq, callee_eq, expired, idx_here;

   // The ring: each cell takes from its upper neighbour, the top cell from
   // the head unit, which sees the slot numbered pos_ff in cell zero.
   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      rstwa_cell #(.AGE_BITS(AGE_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .entry_in  ((k == SLOTS - 1) ? head_entry : cell_entry[(k + 1) % SLOTS]),
         .age_in    ((k == SLOTS - 1) ? head_age   : cell_age[(k + 1) % SLOTS]),
         .entry_out (cell_entry[k]),
         .age_out   (cell_age[k])
      );
   end

   assign cur      = cell_entry[0];
   assign cur_age  = cell_age[0];
   assign last     = (pos_ff == POS_W'(SLOTS - 1));
   assign accept   = req_valid && !req_stall;
   assign pos_port = base_ff + rstwa_pkg::PORT_W'(pos_ff);

   assign caller_eq = (cur.caller_addr == addr_ff) && (cur.caller_port == port_ff);
   assign callee_eq = cur.peer && (cur.callee_addr == addr_ff) &&
                      (cur.callee_port == port_ff);
   assign expired   = CMP_W'(cur_age) >= CMP_W'(timeout_ff);
   assign idx_here  = (CMP_W'(idx_ff) == CMP_W'(pos_ff));

   // Head unit: works on the one slot leaving cell zero.
   always_comb begin
      head_entry = cur;
      head_age   = cur_age;
      hit        = 1'b0;
      free_now   = 1'b0;
      relay_ok   = 1'b0;
      relay_da   = cur.callee_addr;
      relay_dp   = cur.callee_port;
      if (state_ff == rstwa_pkg::CTL_SCAN) begin
         case (op_ff)
            rstwa_pkg::REQ_TICK: begin
               if (cur.valid && (CMP_W'(cur_age) < CMP_W'(timeout_ff)) && (cur_age != '1)) begin
                  head_age = cur_age + AGE_BITS'(1);
               end
            end
            rstwa_pkg::REQ_ALLOC: begin
               if (!done_ff) begin
                  if (cur.valid && (caller_eq || callee_eq)) begin
                     hit      = 1'b1;
                     head_age = '0;
                  end else begin
                     if (cur.valid && expired) begin
                        head_entry = '0;
                        head_age   = '0;
                     end
                     free_now = !cur.valid || expired;
                  end
               end
            end
            rstwa_pkg::REQ_RELAY: begin
               if (idx_here && cur.valid) begin
                  relay_ok = 1'b1;
                  head_age = '0;
                  if (callee_eq) begin
                     relay_da = cur.caller_addr;
                     relay_dp = cur.caller_port;
                  end else if (!cur.peer && !caller_eq) begin
                     head_entry.callee_addr = addr_ff;
                     head_entry.callee_port = port_ff;
                     head_entry.peer        = 1'b1;
                     relay_da = cur.caller_addr;
                     relay_dp = cur.caller_port;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (state_ff == rstwa_pkg::CTL_FILL && pos_ff == free_slot_ff) begin
         head_entry             = '0;
         head_entry.valid       = 1'b1;
         head_entry.caller_addr = addr_ff;
         head_entry.caller_port = port_ff;
         head_age               = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rstwa_pkg::CTL_IDLE: begin
            if (accept && req_type != rstwa_pkg::REQ_NONE) begin
               state_in = rstwa_pkg::CTL_SCAN;
            end
         end
         rstwa_pkg::CTL_SCAN: begin
            if (last) begin
               if (op_ff == rstwa_pkg::REQ_ALLOC && !(done_ff || hit) &&
                   (free_found_ff || free_now)) begin
                  state_in = rstwa_pkg::CTL_FILL;
               end else begin
                  state_in = rstwa_pkg::CTL_RESP;
               end
            end
         end
         rstwa_pkg::CTL_FILL: begin
            if (last) begin
               state_in = rstwa_pkg::CTL_RESP;
            end
         end
         rstwa_pkg::CTL_RESP: begin
            if (!rsp_stall) begin
               state_in = rstwa_pkg::CTL_IDLE;
            end
         end
         default: state_in = rstwa_pkg::CTL_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != rstwa_pkg::CTL_IDLE);
      rsp_valid = (state_ff == rstwa_pkg::CTL_RESP);
      shift_en  = (state_ff == rstwa_pkg::CTL_SCAN) || (state_ff == rstwa_pkg::CTL_FILL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rstwa_pkg::CTL_IDLE;
         timeout_ff    <= rstwa_pkg::TMO_W'(30);
         base_ff       <= rstwa_pkg::PORT_W'(50000);
         pos_ff        <= '0;
         done_ff       <= 1'b0;
         relay_ok_ff   <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            case (csr_index)
               rstwa_pkg::CSR_TIMEOUT:   timeout_ff <= csr_wdata[rstwa_pkg::TMO_W-1:0];
               rstwa_pkg::CSR_PORT_BASE: base_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (shift_en) begin
            pos_ff <= last ? '0 : pos_ff + POS_W'(1);
         end
         if (state_ff == rstwa_pkg::CTL_IDLE) begin
            done_ff       <= 1'b0;
            relay_ok_ff   <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (state_ff == rstwa_pkg::CTL_SCAN) begin
            if (hit)      done_ff     <= 1'b1;
            if (relay_ok) relay_ok_ff <= 1'b1;
            if (free_now && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
         end
      end
   end

   // Transaction fields and the result held for the response channel.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_type;
         addr_ff <= req_src_addr;
         port_ff <= req_src_port;
         idx_ff  <= req_slot_index;
      end
      if (state_ff == rstwa_pkg::CTL_SCAN) begin
         if (free_now && !free_found_ff) begin
            free_slot_ff <= pos_ff;
         end
         if (hit) begin
            res_status_ff <= rstwa_pkg::ST_FOUND;
            res_slot_ff   <= rstwa_pkg::SLOT_W'(pos_ff);
            res_rp_ff     <= pos_port;
            res_da_ff     <= cur.caller_addr;
            res_dp_ff     <= cur.caller_port;
         end else if (relay_ok) begin
            res_status_ff <= rstwa_pkg::ST_RELAYED;
            res_slot_ff   <= rstwa_pkg::SLOT_W'(pos_ff);
            res_rp_ff     <= pos_port;
            res_da_ff     <= relay_da;
            res_dp_ff     <= relay_dp;
         end else if (last) begin
            if (op_ff == rstwa_pkg::REQ_TICK ||
                (op_ff == rstwa_pkg::REQ_ALLOC && !done_ff) ||
                (op_ff == rstwa_pkg::REQ_RELAY && !relay_ok_ff)) begin
               res_slot_ff <= '0;
               res_rp_ff   <= '0;
               res_da_ff   <= '0;
               res_dp_ff   <= '0;
            end
            if (op_ff == rstwa_pkg::REQ_TICK) begin
               res_status_ff <= rstwa_pkg::ST_TICK_DONE;
            end else if (op_ff == rstwa_pkg::REQ_ALLOC && !done_ff) begin
               res_status_ff <= rstwa_pkg::ST_FULL;
            end else if (op_ff == rstwa_pkg::REQ_RELAY && !relay_ok_ff) begin
               res_status_ff <= rstwa_pkg::ST_INVALID;
            end
         end
      end else if (state_ff == rstwa_pkg::CTL_FILL && pos_ff == free_slot_ff) begin
         res_status_ff <= rstwa_pkg::ST_CREATED;
         res_slot_ff   <= rstwa_pkg::SLOT_W'(pos_ff);
         res_rp_ff     <= pos_port;
         res_da_ff     <= addr_ff;
         res_dp_ff     <= port_ff;
      end
   end

   assign rsp_status_code = res_status_ff;
   assign rsp_result_slot = res_slot_ff;
   assign rsp_relay_port  = res_rp_ff;
   assign rsp_dest_addr   = res_da_ff;
   assign rsp_dest_port   = res_dp_ff;

`ifndef ASSERT_OFF
   // The ring must be back in slot order whenever a result is offered.
   a_aligned_at_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pos_ff == '0))
      else $error("session ring not aligned at response");

   // A fill pass only follows an allocate that found a free slot.
   a_fill_has_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rstwa_pkg::CTL_FILL) |-> (op_ff == rstwa_pkg::REQ_ALLOC && free_found_ff))
      else $error("fill pass without a free slot");

   // A real transaction starts a scan in the next cycle.
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type != rstwa_pkg::REQ_NONE) |=> (state_ff == rstwa_pkg::CTL_SCAN))
      else $error("accepted transaction did not start a scan");

   // Scan bookkeeping resets before each new transaction.
   a_flags_clear: assert property (@(posedge clock) disable iff (reset)
      accept |=> (!done_ff && !relay_ok_ff && !free_found_ff))
      else $error("scan flags not cleared at acceptance");
`endif

endmodule
